/* design/nps_pkg.sv */
// shared types, constants and the piece lookup for the nine-patch slicer
// no dependencies; every design file imports this package
package nps_pkg;

    localparam int COORD_BITS = 16;
    localparam int INSET_BITS = 15;
    // working width: holds a coordinate difference and a sum of two insets exactly
    localparam int CALC_W = ((COORD_BITS > INSET_BITS + 1) ? COORD_BITS : INSET_BITS + 1) + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int SLOTS = 10;
    localparam int SLOT_W = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [INSET_BITS-1:0] dim_t;
    typedef logic signed [CALC_W-1:0] calc_t;
    typedef logic [SLOTS-1:0] slot_mask_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [3:0] piece_t;
    typedef logic [1:0] edge_sel_t;

    // configuration register indexes
    localparam logic [2:0] REG_DST_LEFT   = 3'd0;
    localparam logic [2:0] REG_DST_RIGHT  = 3'd1;
    localparam logic [2:0] REG_DST_TOP    = 3'd2;
    localparam logic [2:0] REG_DST_BOTTOM = 3'd3;
    localparam logic [2:0] REG_SRC_LEFT   = 3'd4;
    localparam logic [2:0] REG_SRC_RIGHT  = 3'd5;
    localparam logic [2:0] REG_SRC_TOP    = 3'd6;
    localparam logic [2:0] REG_SRC_BOTTOM = 3'd7;

    typedef struct packed {
        dim_t dst_left;
        dim_t dst_right;
        dim_t dst_top;
        dim_t dst_bottom;
        dim_t src_left;
        dim_t src_right;
        dim_t src_top;
        dim_t src_bottom;
    } insets_t;

    // piece codes, row-major over the 3x3 grid
    localparam piece_t PIECE_TL    = 4'd0;
    localparam piece_t PIECE_TC    = 4'd1;
    localparam piece_t PIECE_TR    = 4'd2;
    localparam piece_t PIECE_ML    = 4'd3;
    localparam piece_t PIECE_MC    = 4'd4;
    localparam piece_t PIECE_MR    = 4'd5;
    localparam piece_t PIECE_BL    = 4'd6;
    localparam piece_t PIECE_BC    = 4'd7;
    localparam piece_t PIECE_BR    = 4'd8;
    localparam piece_t PIECE_WHOLE = 4'd9;

    // emission slots, lowest goes out first
    localparam slot_t SLOT_TL    = 4'd0;
    localparam slot_t SLOT_TR    = 4'd1;
    localparam slot_t SLOT_TC    = 4'd2;
    localparam slot_t SLOT_BL    = 4'd3;
    localparam slot_t SLOT_BR    = 4'd4;
    localparam slot_t SLOT_BC    = 4'd5;
    localparam slot_t SLOT_ML    = 4'd6;
    localparam slot_t SLOT_MR    = 4'd7;
    localparam slot_t SLOT_MC    = 4'd8;
    localparam slot_t SLOT_WHOLE = 4'd9;

    // grid edge indexes: outer edge, inner edge, inner edge, outer edge
    localparam edge_sel_t EDGE_0 = 2'd0;
    localparam edge_sel_t EDGE_1 = 2'd1;
    localparam edge_sel_t EDGE_2 = 2'd2;
    localparam edge_sel_t EDGE_3 = 2'd3;

    typedef struct packed {
        coord_t [3:0] tcol;
        coord_t [3:0] trow;
        coord_t [3:0] scol;
        coord_t [3:0] srow;
        slot_mask_t   mask;
    } entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef struct packed {
        edge_sel_t col_lo;
        edge_sel_t col_hi;
        edge_sel_t row_lo;
        edge_sel_t row_hi;
        piece_t    piece;
    } slot_info_t;

    function automatic slot_info_t slot_info(input slot_t slot);
        slot_info_t info;
        case (slot)
            SLOT_TL:    info = '{EDGE_0, EDGE_1, EDGE_0, EDGE_1, PIECE_TL};
            SLOT_TR:    info = '{EDGE_2, EDGE_3, EDGE_0, EDGE_1, PIECE_TR};
            SLOT_TC:    info = '{EDGE_1, EDGE_2, EDGE_0, EDGE_1, PIECE_TC};
            SLOT_BL:    info = '{EDGE_0, EDGE_1, EDGE_2, EDGE_3, PIECE_BL};
            SLOT_BR:    info = '{EDGE_2, EDGE_3, EDGE_2, EDGE_3, PIECE_BR};
            SLOT_BC:    info = '{EDGE_1, EDGE_2, EDGE_2, EDGE_3, PIECE_BC};
            SLOT_ML:    info = '{EDGE_0, EDGE_1, EDGE_1, EDGE_2, PIECE_ML};
            SLOT_MR:    info = '{EDGE_2, EDGE_3, EDGE_1, EDGE_2, PIECE_MR};
            SLOT_MC:    info = '{EDGE_1, EDGE_2, EDGE_1, EDGE_2, PIECE_MC};
            default:    info = '{EDGE_0, EDGE_3, EDGE_0, EDGE_3, PIECE_WHOLE};
        endcase
        return info;
    endfunction

endpackage

/* design/nps_front.sv */
// front end: classifies an incoming item and forms all grid edges
// depends on nps_pkg
module nps_front (
    input  nps_pkg::coord_t  rect_left,
    input  nps_pkg::coord_t  rect_top,
    input  nps_pkg::coord_t  rect_right,
    input  nps_pkg::coord_t  rect_bottom,
    input  nps_pkg::dim_t    image_width,
    input  nps_pkg::dim_t    image_height,
    input  nps_pkg::insets_t insets,
    output nps_pkg::entry_t  entry
);
    import nps_pkg::*;

    calc_t x_e, y_e, r_e, b_e, ws_e, hs_e;
    calc_t ld_e, rd_e, td_e, bd_e, ls_e, rs_e, ts_e, bs_e;
    calc_t wd, hd;
    logic  fallback;
    logic  use_l, use_r, use_t, use_b;

    function automatic calc_t sx(input coord_t v);
        return {{(CALC_W-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic calc_t zx(input dim_t v);
        return {{(CALC_W-INSET_BITS){1'b0}}, v};
    endfunction

    function automatic coord_t wrap(input calc_t v);
        return v[COORD_BITS-1:0];
    endfunction

    always_comb
    begin
        x_e  = sx(rect_left);
        y_e  = sx(rect_top);
        r_e  = sx(rect_right);
        b_e  = sx(rect_bottom);
        ws_e = zx(image_width);
        hs_e = zx(image_height);
        ld_e = zx(insets.dst_left);
        rd_e = zx(insets.dst_right);
        td_e = zx(insets.dst_top);
        bd_e = zx(insets.dst_bottom);
        ls_e = zx(insets.src_left);
        rs_e = zx(insets.src_right);
        ts_e = zx(insets.src_top);
        bs_e = zx(insets.src_bottom);

        wd = r_e - x_e;
        hd = b_e - y_e;
        // too small for its borders, inverted rectangles included
        fallback = (wd < ld_e + rd_e) || (hd < td_e + bd_e) ||
                   (ws_e < ls_e + rs_e) || (hs_e < ts_e + bs_e);

        use_l = (insets.dst_left != '0) && (insets.src_left != '0);
        use_r = (insets.dst_right != '0) && (insets.src_right != '0);
        use_t = (insets.dst_top != '0) && (insets.src_top != '0);
        use_b = (insets.dst_bottom != '0) && (insets.src_bottom != '0);

        entry.tcol[EDGE_0] = rect_left;
        entry.tcol[EDGE_1] = wrap(x_e + ld_e);
        entry.tcol[EDGE_2] = wrap(r_e - rd_e);
        entry.tcol[EDGE_3] = rect_right;
        entry.trow[EDGE_0] = rect_top;
        entry.trow[EDGE_1] = wrap(y_e + td_e);
        entry.trow[EDGE_2] = wrap(b_e - bd_e);
        entry.trow[EDGE_3] = rect_bottom;
        entry.scol[EDGE_0] = '0;
        entry.scol[EDGE_1] = wrap(ls_e);
        entry.scol[EDGE_2] = wrap(ws_e - rs_e);
        entry.scol[EDGE_3] = wrap(ws_e);
        entry.srow[EDGE_0] = '0;
        entry.srow[EDGE_1] = wrap(ts_e);
        entry.srow[EDGE_2] = wrap(hs_e - bs_e);
        entry.srow[EDGE_3] = wrap(hs_e);

        entry.mask = '0;
        if (fallback)
        begin
            entry.mask[SLOT_WHOLE] = 1'b1;
        end
        else
        begin
            entry.mask[SLOT_TL] = use_t & use_l;
            entry.mask[SLOT_TR] = use_t & use_r;
            entry.mask[SLOT_TC] = use_t;
            entry.mask[SLOT_BL] = use_b & use_l;
            entry.mask[SLOT_BR] = use_b & use_r;
            entry.mask[SLOT_BC] = use_b;
            entry.mask[SLOT_ML] = use_l;
            entry.mask[SLOT_MR] = use_r;
            entry.mask[SLOT_MC] = 1'b1;
        end
    end

endmodule

/* design/nps_queue.sv */
// short item queue between the front and back ends
// depends on nps_pkg
module nps_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nps_pkg::entry_t  push_entry,
    input  logic             pop,
    output nps_pkg::entry_t  head,
    output nps_pkg::q_stat_t stat
);
    import nps_pkg::*;

    entry_t              store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head       = store_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

/* design/nps_back.sv */
// back end: walks the pieces of one item and drives one command per cycle while out_stall is low
// depends on nps_pkg
module nps_back (
    input  logic             clk,
    input  logic             rst_n,
    input  nps_pkg::entry_t  head,
    input  nps_pkg::q_stat_t q_stat,
    output logic             pop,
    output logic             busy,
    output logic             out_valid,
    input  logic             out_stall,
    output nps_pkg::coord_t  target_left,
    output nps_pkg::coord_t  target_top,
    output nps_pkg::coord_t  target_right,
    output nps_pkg::coord_t  target_bottom,
    output nps_pkg::coord_t  source_left,
    output nps_pkg::coord_t  source_top,
    output nps_pkg::coord_t  source_right,
    output nps_pkg::coord_t  source_bottom,
    output nps_pkg::piece_t  piece,
    output logic             last
);
    import nps_pkg::*;

    entry_t     cur_reg;
    slot_mask_t mask_reg, mask_next;
    slot_mask_t rest;
    slot_t      slot;
    slot_info_t info;
    logic       adv, emit;
    logic       out_valid_reg, out_valid_next;
    coord_t     tl_reg, tt_reg, tr_reg, tb_reg;
    coord_t     sl_reg, st_reg, sr_reg, sb_reg;
    piece_t     piece_reg;
    logic       last_reg;

    always_comb
    begin
        slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                slot = SLOT_W'(i);
            end
        end
        info = slot_info(slot);
        // drop the lowest pending slot
        rest = mask_reg & (mask_reg - 1'b1);

        busy = (mask_reg != '0);
        adv  = !out_valid_reg || !out_stall;
        emit = adv && busy;
        pop  = !q_stat.empty && (!busy || (emit && rest == '0));

        mask_next = mask_reg;
        if (pop)
        begin
            mask_next = head.mask;
        end
        else if (emit)
        begin
            mask_next = rest;
        end
        out_valid_next = adv ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (emit)
        begin
            tl_reg    <= cur_reg.tcol[info.col_lo];
            tr_reg    <= cur_reg.tcol[info.col_hi];
            tt_reg    <= cur_reg.trow[info.row_lo];
            tb_reg    <= cur_reg.trow[info.row_hi];
            sl_reg    <= cur_reg.scol[info.col_lo];
            sr_reg    <= cur_reg.scol[info.col_hi];
            st_reg    <= cur_reg.srow[info.row_lo];
            sb_reg    <= cur_reg.srow[info.row_hi];
            piece_reg <= info.piece;
            last_reg  <= (rest == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign target_left   = tl_reg;
    assign target_top    = tt_reg;
    assign target_right  = tr_reg;
    assign target_bottom = tb_reg;
    assign source_left   = sl_reg;
    assign source_top    = st_reg;
    assign source_right  = sr_reg;
    assign source_bottom = sb_reg;
    assign piece         = piece_reg;
    assign last          = last_reg;

endmodule

/* design/nine_patch_slicer.sv */
// an item passes through the queue, the back end's current-item register and its output register
// throughput: one command per cycle while out_stall is low; an item gives 1 to 9 commands,
// one per drawn piece; the queue holds 2 classified items
// reset: insets clear to 0, queue and output empty
// depends on nps_pkg, nps_front, nps_queue, nps_back
module nine_patch_slicer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [14:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  nps_pkg::coord_t      rect_left,
    input  nps_pkg::coord_t      rect_top,
    input  nps_pkg::coord_t      rect_right,
    input  nps_pkg::coord_t      rect_bottom,
    input  nps_pkg::dim_t        image_width,
    input  nps_pkg::dim_t        image_height,
    output logic                 out_valid,
    input  logic                 out_stall,
    output nps_pkg::coord_t      target_left,
    output nps_pkg::coord_t      target_top,
    output nps_pkg::coord_t      target_right,
    output nps_pkg::coord_t      target_bottom,
    output nps_pkg::coord_t      source_left,
    output nps_pkg::coord_t      source_top,
    output nps_pkg::coord_t      source_right,
    output nps_pkg::coord_t      source_bottom,
    output nps_pkg::piece_t      piece,
    output logic                 last
);
    import nps_pkg::*;

    insets_t insets_reg, insets_next;
    entry_t  front_entry, head;
    q_stat_t q_stat;
    logic    push, pop, busy;

    always_comb
    begin
        insets_next = insets_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DST_LEFT:   insets_next.dst_left   = cfg_data;
                REG_DST_RIGHT:  insets_next.dst_right  = cfg_data;
                REG_DST_TOP:    insets_next.dst_top    = cfg_data;
                REG_DST_BOTTOM: insets_next.dst_bottom = cfg_data;
                REG_SRC_LEFT:   insets_next.src_left   = cfg_data;
                REG_SRC_RIGHT:  insets_next.src_right  = cfg_data;
                REG_SRC_TOP:    insets_next.src_top    = cfg_data;
                REG_SRC_BOTTOM: insets_next.src_bottom = cfg_data;
                default:        insets_next = insets_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insets_reg <= '0;
        end
        else
        begin
            insets_reg <= insets_next;
        end
    end

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    nps_front u_front (
        .rect_left    (rect_left),
        .rect_top     (rect_top),
        .rect_right   (rect_right),
        .rect_bottom  (rect_bottom),
        .image_width  (image_width),
        .image_height (image_height),
        .insets       (insets_reg),
        .entry        (front_entry)
    );

    nps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    nps_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .busy          (busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .target_left   (target_left),
        .target_top    (target_top),
        .target_right  (target_right),
        .target_bottom (target_bottom),
        .source_left   (source_left),
        .source_top    (source_top),
        .source_right  (source_right),
        .source_bottom (source_bottom),
        .piece         (piece),
        .last          (last)
    );

    // the whole-image command is always the only one of its item
    a_whole_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && piece == PIECE_WHOLE |-> last)
        else $error("whole-image command without last");

    // a waiting item is picked up by an idle back end on the next edge
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        !q_stat.empty && !busy |=> busy)
        else $error("back end idle while queue holds an item");

    // a new command only appears when the back end had pieces pending
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(busy))
        else $error("command emitted with no pending piece");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// testbench for nine_patch_slicer: a directed table, then random phases under varied insets, with every
// command checked against a behavioral slicer or a typed expected command; depends on nps_pkg and the rtl
module tb_top;
    import nps_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;
    localparam int HOLD_AFTER_ITEMS = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES = 12;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 50;
    localparam int WIDE_PHASE = 4;
    localparam int MAX_PRINTED = 50;

    typedef struct {
        coord_t left;
        coord_t top;
        coord_t right;
        coord_t bottom;
        dim_t   width;
        dim_t   height;
    } rect_item_t;

    typedef struct {
        coord_t target_left;
        coord_t target_top;
        coord_t target_right;
        coord_t target_bottom;
        coord_t source_left;
        coord_t source_top;
        coord_t source_right;
        coord_t source_bottom;
        piece_t piece;
        logic   last;
    } blit_t;

    typedef enum logic [1:0] {STEP_CFG, STEP_ITEM, STEP_TYPED} step_kind_t;

    typedef struct {
        step_kind_t kind;
        logic [2:0] index;
        dim_t       value;
        rect_item_t item;
        blit_t      want;
    } step_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_TOGGLE, STALL_HEAVY} stall_mode_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [14:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    coord_t      rect_left = '0;
    coord_t      rect_top = '0;
    coord_t      rect_right = '0;
    coord_t      rect_bottom = '0;
    dim_t        image_width = '0;
    dim_t        image_height = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    coord_t      target_left;
    coord_t      target_top;
    coord_t      target_right;
    coord_t      target_bottom;
    coord_t      source_left;
    coord_t      source_top;
    coord_t      source_right;
    coord_t      source_bottom;
    piece_t      piece;
    logic        last;

    insets_t insets = '0;
    blit_t   expected_cmds [$];
    int      items_taken = 0;
    int      cmds_checked = 0;
    int      fallbacks_seen = 0;
    int      nine_piece_items = 0;
    int      inset_writes = 0;
    int      mismatches = 0;
    int      burst_left = 0;
    int      quiet_cycles = 0;

    nine_patch_slicer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rect_left     (rect_left),
        .rect_top      (rect_top),
        .rect_right    (rect_right),
        .rect_bottom   (rect_bottom),
        .image_width   (image_width),
        .image_height  (image_height),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .target_left   (target_left),
        .target_top    (target_top),
        .target_right  (target_right),
        .target_bottom (target_bottom),
        .source_left   (source_left),
        .source_top    (source_top),
        .source_right  (source_right),
        .source_bottom (source_bottom),
        .piece         (piece),
        .last          (last)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic rect_item_t make_item(int l, int t, int r, int b, int w, int h);
        rect_item_t it;
        it.left = coord_t'(l);
        it.top = coord_t'(t);
        it.right = coord_t'(r);
        it.bottom = coord_t'(b);
        it.width = dim_t'(w);
        it.height = dim_t'(h);
        return it;
    endfunction

    function automatic blit_t make_blit(int tl, int tt, int tr, int tb,
                                        int sl, int st, int sr, int sb, piece_t p);
        blit_t c;
        c.target_left = coord_t'(tl);
        c.target_top = coord_t'(tt);
        c.target_right = coord_t'(tr);
        c.target_bottom = coord_t'(tb);
        c.source_left = coord_t'(sl);
        c.source_top = coord_t'(st);
        c.source_right = coord_t'(sr);
        c.source_bottom = coord_t'(sb);
        c.piece = p;
        c.last = 1'b0;
        return c;
    endfunction

    // one command covering the whole rectangle and the whole image
    function automatic blit_t single_cmd(rect_item_t it, piece_t p);
        blit_t c;
        c = make_blit(int'(it.left), int'(it.top), int'(it.right), int'(it.bottom),
                      0, 0, int'(it.width), int'(it.height), p);
        c.last = 1'b1;
        return c;
    endfunction

    function automatic step_t cfg_step(logic [2:0] index, int value);
        step_t s;
        s.kind = STEP_CFG;
        s.index = index;
        s.value = dim_t'(value);
        return s;
    endfunction

    function automatic step_t item_step(rect_item_t it);
        step_t s;
        s.kind = STEP_ITEM;
        s.item = it;
        return s;
    endfunction

    function automatic step_t typed_step(rect_item_t it, piece_t p);
        step_t s;
        s.kind = STEP_TYPED;
        s.item = it;
        s.want = single_cmd(it, p);
        return s;
    endfunction

    // splits one rectangle into its blit commands under the current insets
    function automatic void slice_rect(rect_item_t it);
        int x, y, r, b, ws, hs, wd, hd;
        int ld, rd, td, bd, ls, rs, ts, bs;
        bit use_l, use_r;
        bit row_on [3];
        int t0 [3];
        int t1 [3];
        int s0 [3];
        int s1 [3];
        piece_t code_l [3];
        piece_t code_r [3];
        piece_t code_c [3];
        blit_t cmds [$];
        x = int'(it.left);
        y = int'(it.top);
        r = int'(it.right);
        b = int'(it.bottom);
        ws = int'(it.width);
        hs = int'(it.height);
        wd = r - x;
        hd = b - y;
        ld = int'(insets.dst_left);
        rd = int'(insets.dst_right);
        td = int'(insets.dst_top);
        bd = int'(insets.dst_bottom);
        ls = int'(insets.src_left);
        rs = int'(insets.src_right);
        ts = int'(insets.src_top);
        bs = int'(insets.src_bottom);
        if (wd < ld + rd || hd < td + bd || ws < ls + rs || hs < ts + bs)
        begin
            cmds.push_back(make_blit(x, y, r, b, 0, 0, ws, hs, PIECE_WHOLE));
        end
        else
        begin
            use_l = (ld > 0) && (ls > 0);
            use_r = (rd > 0) && (rs > 0);
            // emission order of rows: top, bottom, middle
            row_on[0] = (td > 0) && (ts > 0);
            t0[0] = y;
            t1[0] = y + td;
            s0[0] = 0;
            s1[0] = ts;
            code_l[0] = PIECE_TL;
            code_r[0] = PIECE_TR;
            code_c[0] = PIECE_TC;
            row_on[1] = (bd > 0) && (bs > 0);
            t0[1] = y + hd - bd;
            t1[1] = y + hd;
            s0[1] = hs - bs;
            s1[1] = hs;
            code_l[1] = PIECE_BL;
            code_r[1] = PIECE_BR;
            code_c[1] = PIECE_BC;
            row_on[2] = 1'b1;
            t0[2] = y + td;
            t1[2] = y + hd - bd;
            s0[2] = ts;
            s1[2] = hs - bs;
            code_l[2] = PIECE_ML;
            code_r[2] = PIECE_MR;
            code_c[2] = PIECE_MC;
            for (int k = 0; k < 3; k++)
            begin
                if (row_on[k])
                begin
                    if (use_l)
                        cmds.push_back(make_blit(x, t0[k], x + ld, t1[k],
                                                 0, s0[k], ls, s1[k], code_l[k]));
                    if (use_r)
                        cmds.push_back(make_blit(x + wd - rd, t0[k], x + wd, t1[k],
                                                 ws - rs, s0[k], ws, s1[k], code_r[k]));
                    cmds.push_back(make_blit(x + ld, t0[k], x + wd - rd, t1[k],
                                             ls, s0[k], ws - rs, s1[k], code_c[k]));
                end
            end
            if (cmds.size() == 9)
                nine_piece_items++;
        end
        cmds[cmds.size() - 1].last = 1'b1;
        foreach (cmds[i])
            expected_cmds.push_back(cmds[i]);
    endfunction

    function automatic dim_t pick_inset(bit wide);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2)
            return '0;
        if (wide)
            return dim_t'($urandom_range(1000, 16000));
        if (roll < 9)
            return dim_t'($urandom_range(1, 24));
        return dim_t'($urandom_range(25, 300));
    endfunction

    // start coordinate that keeps start and start + span inside the signed range
    function automatic int place(int span);
        int lo, hi;
        lo = (span < 0) ? -span : 0;
        hi = (span < 0) ? 65535 : 65535 - span;
        return int'($urandom_range(lo, hi)) - 32768;
    endfunction

    function automatic rect_item_t random_item();
        int roll, w, h, iw, ih, x, y;
        rect_item_t it;
        roll = $urandom_range(0, 99);
        if (roll < 15)
        begin
            // noise: every field fully random
            it.left = coord_t'($urandom);
            it.top = coord_t'($urandom);
            it.right = coord_t'($urandom);
            it.bottom = coord_t'($urandom);
            it.width = dim_t'($urandom);
            it.height = dim_t'($urandom);
            return it;
        end
        w = int'(insets.dst_left) + int'(insets.dst_right)
            + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 60));
        h = int'(insets.dst_top) + int'(insets.dst_bottom)
            + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 60));
        iw = int'(insets.src_left) + int'(insets.src_right) + $urandom_range(0, 50);
        ih = int'(insets.src_top) + int'(insets.src_bottom) + $urandom_range(0, 50);
        if (roll < 27)
        begin
            // near miss: one dimension just short of its insets
            case ($urandom_range(0, 3))
                0: w = int'(insets.dst_left) + int'(insets.dst_right) - $urandom_range(1, 3);
                1: h = int'(insets.dst_top) + int'(insets.dst_bottom) - $urandom_range(1, 3);
                2: iw = int'(insets.src_left) + int'(insets.src_right) - $urandom_range(1, 3);
                default: ih = int'(insets.src_top) + int'(insets.src_bottom) - $urandom_range(1, 3);
            endcase
        end
        if (w > 65535)
            w = 65535;
        if (h > 65535)
            h = 65535;
        iw = (iw < 0) ? 0 : ((iw > 32767) ? 32767 : iw);
        ih = (ih < 0) ? 0 : ((ih > 32767) ? 32767 : ih);
        x = place(w);
        y = place(h);
        return make_item(x, y, x + w, y + h, iw, ih);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch at command %0d: %s", cmds_checked, msg);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    task automatic write_inset(input logic [2:0] index, input dim_t value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        inset_writes++;
        case (index)
            REG_DST_LEFT:   insets.dst_left = value;
            REG_DST_RIGHT:  insets.dst_right = value;
            REG_DST_TOP:    insets.dst_top = value;
            REG_DST_BOTTOM: insets.dst_bottom = value;
            REG_SRC_LEFT:   insets.src_left = value;
            REG_SRC_RIGHT:  insets.src_right = value;
            REG_SRC_TOP:    insets.src_top = value;
            default:        insets.src_bottom = value;
        endcase
        @(posedge clk);
    endtask

    // stop offering and wait until every command is back
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // sender bursts with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    task automatic offer_item(input rect_item_t it, input bit typed, input blit_t want);
        in_valid <= 1'b1;
        rect_left <= it.left;
        rect_top <= it.top;
        rect_right <= it.right;
        rect_bottom <= it.bottom;
        image_width <= it.width;
        image_height <= it.height;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_taken++;
        if (typed)
            expected_cmds.push_back(want);
        else
            slice_rect(it);
    endtask

    // receiver stall pattern, with one long hold-off to back the block up
    initial
    begin
        stall_mode_t mode;
        int mode_left;
        bit hold_done;
        mode = STALL_NONE;
        mode_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_taken >= HOLD_AFTER_ITEMS)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_SPARSE: out_stall <= ($urandom_range(0, 2) == 0);
                STALL_TOGGLE: out_stall <= ~out_stall;
                default:      out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        blit_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_cmds.size() == 0)
            begin
                report_mismatch($sformatf("command with nothing pending, piece %0d", piece));
            end
            else
            begin
                want = expected_cmds.pop_front();
                check_field("target_left", target_left, want.target_left);
                check_field("target_top", target_top, want.target_top);
                check_field("target_right", target_right, want.target_right);
                check_field("target_bottom", target_bottom, want.target_bottom);
                check_field("source_left", source_left, want.source_left);
                check_field("source_top", source_top, want.source_top);
                check_field("source_right", source_right, want.source_right);
                check_field("source_bottom", source_bottom, want.source_bottom);
                check_field("piece", piece, want.piece);
                check_field("last", last, want.last);
                if (piece == PIECE_WHOLE)
                    fallbacks_seen++;
                cmds_checked++;
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        step_t rows [$];
        blit_t no_want;
        bit wide;
        // zero insets after reset: a plain rectangle comes back as one centre piece
        rows.push_back(typed_step(make_item(0, 0, 100, 50, 10, 10), PIECE_MC));
        rows.push_back(typed_step(make_item(-32768, -32768, 32767, 32767, 32767, 32767),
                                  PIECE_MC));
        rows.push_back(typed_step(make_item(10, 0, 5, 5, 1, 1), PIECE_WHOLE));
        rows.push_back(typed_step(make_item(0, 0, 0, 0, 0, 0), PIECE_MC));
        rows.push_back(cfg_step(REG_DST_LEFT, 4));
        rows.push_back(cfg_step(REG_DST_RIGHT, 6));
        rows.push_back(cfg_step(REG_DST_TOP, 3));
        rows.push_back(cfg_step(REG_DST_BOTTOM, 5));
        rows.push_back(cfg_step(REG_SRC_LEFT, 2));
        rows.push_back(cfg_step(REG_SRC_RIGHT, 3));
        rows.push_back(cfg_step(REG_SRC_TOP, 1));
        rows.push_back(cfg_step(REG_SRC_BOTTOM, 2));
        rows.push_back(item_step(make_item(10, 20, 110, 80, 20, 20)));
        // exact fit: centre pieces of zero size
        rows.push_back(item_step(make_item(0, 0, 10, 8, 5, 3)));
        rows.push_back(typed_step(make_item(0, 0, 9, 100, 100, 100), PIECE_WHOLE));
        rows.push_back(typed_step(make_item(0, 0, 100, 7, 100, 100), PIECE_WHOLE));
        rows.push_back(typed_step(make_item(0, 0, 100, 100, 4, 100), PIECE_WHOLE));
        rows.push_back(typed_step(make_item(0, 0, 100, 100, 100, 2), PIECE_WHOLE));
        rows.push_back(item_step(make_item(-100, -200, -50, -150, 50, 60)));
        // left column and bottom row dropped
        rows.push_back(cfg_step(REG_DST_LEFT, 0));
        rows.push_back(cfg_step(REG_SRC_BOTTOM, 0));
        rows.push_back(item_step(make_item(0, 0, 50, 50, 30, 30)));
        rows.push_back(item_step(make_item(-7, -9, 6, 8, 5, 1)));
        // only the middle centre piece left
        rows.push_back(cfg_step(REG_SRC_RIGHT, 0));
        rows.push_back(cfg_step(REG_SRC_TOP, 0));
        rows.push_back(item_step(make_item(0, 0, 6, 8, 2, 0)));
        rows.push_back(typed_step(make_item(0, 0, 5, 100, 100, 100), PIECE_WHOLE));
        rows.push_back(cfg_step(REG_DST_LEFT, 32767));
        rows.push_back(cfg_step(REG_DST_RIGHT, 32767));
        rows.push_back(cfg_step(REG_DST_TOP, 32767));
        rows.push_back(cfg_step(REG_DST_BOTTOM, 32767));
        rows.push_back(cfg_step(REG_SRC_LEFT, 32767));
        rows.push_back(cfg_step(REG_SRC_RIGHT, 32767));
        rows.push_back(cfg_step(REG_SRC_TOP, 32767));
        rows.push_back(cfg_step(REG_SRC_BOTTOM, 32767));
        rows.push_back(typed_step(make_item(-32768, -32768, 32767, 32767, 32767, 32767),
                                  PIECE_WHOLE));
        rows.push_back(cfg_step(REG_SRC_LEFT, 1));
        rows.push_back(cfg_step(REG_SRC_RIGHT, 1));
        rows.push_back(cfg_step(REG_SRC_TOP, 1));
        rows.push_back(cfg_step(REG_SRC_BOTTOM, 1));
        rows.push_back(item_step(make_item(-32768, -32768, 32767, 32767, 32767, 32767)));
        rows.push_back(item_step(make_item(-32768, -32768, 32766, 32767, 2, 2)));
        rows.push_back(typed_step(make_item(32767, 32767, -32768, -32768, 0, 0), PIECE_WHOLE));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            case (rows[i].kind)
                STEP_CFG:
                begin
                    drain(SETTLE_CYCLES);
                    write_inset(rows[i].index, rows[i].value);
                end
                STEP_ITEM:
                begin
                    pace();
                    offer_item(rows[i].item, 1'b0, no_want);
                end
                default:
                begin
                    pace();
                    offer_item(rows[i].item, 1'b1, rows[i].want);
                end
            endcase
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wide = (phase == WIDE_PHASE);
            drain(SETTLE_CYCLES);
            write_inset(REG_DST_LEFT, pick_inset(wide));
            write_inset(REG_DST_RIGHT, pick_inset(wide));
            write_inset(REG_DST_TOP, pick_inset(wide));
            write_inset(REG_DST_BOTTOM, pick_inset(wide));
            write_inset(REG_SRC_LEFT, pick_inset(wide));
            write_inset(REG_SRC_RIGHT, pick_inset(wide));
            write_inset(REG_SRC_TOP, pick_inset(wide));
            write_inset(REG_SRC_BOTTOM, pick_inset(wide));
            repeat (PHASE_ITEMS)
            begin
                pace();
                offer_item(random_item(), 1'b0, no_want);
            end
        end

        drain(END_CYCLES);
        $display("tb_top: %0d rectangles sliced across %0d inset writes, %0d commands checked",
                 items_taken, inset_writes, cmds_checked);
        $display("tb_top: %0d whole-image fallbacks, %0d full nine-piece splits, %0d mismatches",
                 fallbacks_seen, nine_piece_items, mismatches);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
